// ===== hdl/mrf_pkg.sv =====
// Package: shared types, constants and the CRC-16/MODBUS byte step for the request framer.
package mrf_pkg;

  // CRC-16/MODBUS constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame layout: six payload bytes, then CRC low, then CRC high
  localparam int          FRAME_LEN   = 8;
  localparam int          PAYLOAD_LEN = 6;
  localparam int          IDX_W       = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] CRC_LO_IDX = IDX_W'(PAYLOAD_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_LEN - 1);

  // Default depth of the queue between front and back
  localparam int          QUEUE_DEPTH = 2;

  // Input word
  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_register;
    logic [15:0] point_count;
  } req_t;

  // Output word
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } rsp_t;

  // Six payload bytes, first byte in the top bits
  typedef logic [8*PAYLOAD_LEN-1:0] frame_t;

  // One byte into the CRC, bit-serial reflected form
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== hdl/mrf_front.sv =====
// Front stage: accepts requests, rebases the start register and builds the payload bytes.
module mrf_front
  import mrf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  req_t   in_data,
  output logic   push_valid,
  input  logic   push_ready,
  output frame_t push_frame
);

  logic   s_valid;
  frame_t s_frame;
  logic [15:0] zb_addr;

  // One-based register number to zero-based address, wraps at zero
  assign zb_addr = in_data.start_register - 16'd1;

  assign in_ready   = !s_valid || push_ready;
  assign push_valid = s_valid;
  assign push_frame = s_frame;

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_frame <= {in_data.slave_address, in_data.function_code, zb_addr,
                  in_data.point_count};
    end
  end

endmodule

// ===== hdl/mrf_queue.sv =====
// Short queue of payload frames between the front stage and the byte serializer.
module mrf_queue
  import mrf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  frame_t push_frame,
  output logic   pop_valid,
  input  logic   pop,
  output frame_t pop_frame
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_frame  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop requested from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CW'(1)))
    else $error("fill count missed a push");

endmodule

// ===== hdl/mrf_back.sv =====
// Back end: serializes one frame per request, folding the CRC in as payload bytes go out.
module mrf_back
  import mrf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   frame_valid,
  input  frame_t frame,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output rsp_t   out_data
);

  logic [IDX_W-1:0] idx;
  logic [15:0]      crc;
  logic [15:0]      crc_next;
  logic [7:0]       pay_byte;
  logic [7:0]       byte_sel;
  logic             load;

  assign load = frame_valid && (!out_valid || out_ready);
  assign pop  = load && (idx == LAST_IDX);

  // Byte select for the current position, and the next CRC value
  always_comb begin
    pay_byte = frame[8*PAYLOAD_LEN-1 -: 8];
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      if (idx == IDX_W'(i)) pay_byte = frame[8*(PAYLOAD_LEN-i)-1 -: 8];
    end
    crc_next = crc_add_byte(crc, pay_byte);
    if (idx == CRC_LO_IDX)      byte_sel = crc[7:0];
    else if (idx == LAST_IDX)   byte_sel = crc[15:8];
    else                        byte_sel = pay_byte;
  end

  // Position counter, running CRC and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= idx + IDX_W'(1);
      if (idx == LAST_IDX) begin
        crc <= CRC_INIT;
      end else if (idx < CRC_LO_IDX) begin
        crc <= crc_next;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.frame_byte <= byte_sel;
      out_data.last_byte  <= (idx == LAST_IDX);
    end
  end

  a_crc_fresh: assert property (@(posedge clk) disable iff (rst)
    (idx == '0) |-> (crc == CRC_INIT))
    else $error("CRC not at initial value at frame start");

  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && out_data.last_byte))
    else $error("frame released without last word");

  a_last_then_new: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("position counter not back at frame start");

endmodule

// ===== hdl/modbus_rtu_request_framer.sv =====
// Top level: Modbus RTU request framer with CRC-16/MODBUS, front stage, queue and serializer.
//
//   channel  | handshake            | word
//   ---------+----------------------+---------------------------------------------
//   in       | in_valid / in_ready  | in_data  : req_t (address, function, reg, count)
//   out      | out_valid / out_ready| out_data : rsp_t (frame_byte, last_byte)
//
// Each request yields eight output words, one per cycle while out_ready is high;
// the single byte-wide output register sets that rate.
// An accepted request passes the front register, the queue memory and the output register.
// The front register and the frame queue keep accepting requests while the
// serializer stalls on out_ready; in_ready drops only when both are full.
// Reset (rst, synchronous) clears all valid flags, the queue, the byte position and the CRC.
module modbus_rtu_request_framer
  import mrf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  logic   push_valid;
  logic   push_ready;
  frame_t push_frame;
  logic   q_valid;
  logic   q_pop;
  frame_t q_frame;

  mrf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  mrf_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_frame  (q_frame)
  );

  mrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (q_valid),
    .frame       (q_frame),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
